### rtl/sab_pkg.sv
// shared constants, codes and types of the scaled alpha image blit engine
// used by sab_div and scaled_alpha_image_blit; depends on nothing
`default_nettype none
package sab_pkg;

  localparam int unsigned SCREEN_MAX_W = 256;
  localparam int unsigned SCREEN_MAX_H = 256;
  localparam int unsigned IMAGE_MAX_W  = 64;
  localparam int unsigned IMAGE_MAX_H  = 64;

  localparam int unsigned POS_W      = 13;
  localparam int unsigned BOX_W      = 12;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned IMG_REG_W  = 7;
  localparam int unsigned WIN_REG_W  = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned TEX_W      = 32;
  localparam int unsigned FB_W       = 24;
  localparam int unsigned CW         = 16;

  localparam int unsigned IMG_MAX_DIM = (IMAGE_MAX_W > IMAGE_MAX_H) ? IMAGE_MAX_W : IMAGE_MAX_H;
  localparam int unsigned IMG_DIM_W   = $clog2(IMG_MAX_DIM + 1);
  localparam int unsigned SW_W        = $clog2(SCREEN_MAX_W + 1);
  localparam int unsigned ROW_W       = $clog2(SCREEN_MAX_H);
  localparam int unsigned COL_W       = $clog2(SCREEN_MAX_W);
  localparam int unsigned FB_AW       = $clog2(SCREEN_MAX_W * SCREEN_MAX_H);
  localparam int unsigned TEX_AW      = $clog2(IMAGE_MAX_W * IMAGE_MAX_H);
  localparam int unsigned DVD_W       = BOX_W + IMG_DIM_W + 1;
  localparam int unsigned DVS_W       = BOX_W;
  localparam int unsigned DCNT_W      = $clog2(DVD_W + 1);

  localparam int unsigned IMG_W_RST = 64;
  localparam int unsigned IMG_H_RST = 64;
  localparam int unsigned WIN_W_RST = 256;
  localparam int unsigned WIN_H_RST = 256;
  localparam int unsigned SCR_W_RST = 256;
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_DRAW  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_IMG_W    = 3'd0,
    CFG_IMG_H    = 3'd1,
    CFG_IMG_PRES = 3'd2,
    CFG_WIN_W    = 3'd3,
    CFG_WIN_H    = 3'd4,
    CFG_OFF_X    = 3'd5,
    CFG_OFF_Y    = 3'd6,
    CFG_SCR_W    = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FIT,
    ST_FITW,
    ST_CLIP,
    ST_CHK,
    ST_DSX,
    ST_DSY,
    ST_D0X,
    ST_D0Y,
    ST_DRAW,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

### rtl/sab_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; contents undefined until written
`default_nettype none
module sab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/sab_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on sab_pkg for widths and the request and response structs
`default_nettype none
module sab_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sab_pkg::div_req_t req_i,
  output sab_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DVDW = sab_pkg::DVD_W;
  localparam int unsigned DVSW = sab_pkg::DVS_W;
  localparam int unsigned CNTW = sab_pkg::DCNT_W;

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DVDW-1:0] quot_q;
  logic [DVSW-1:0] rem_q, dvs_q;
  logic [DVSW:0]   trial, diff;
  logic            ge;
  logic [DVSW-1:0] rem_d;

  always_comb begin
    trial = {rem_q, quot_q[DVDW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? diff[DVSW-1:0] : trial[DVSW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DVDW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= {quot_q[DVDW-2:0], ge};
      rem_q  <= rem_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

### rtl/scaled_alpha_image_blit.sv
// top level of the scaled alpha image blit engine: command fsm, draw pipeline, stores
// depends on sab_pkg, sab_ram and sab_div
//
// One command is taken at a time. A draw first runs five divisions for setup in the shared
// serial divider (aspect fit, texel steps, first texel), then visits one clipped pixel
// per cycle through a read-blend-write pipeline on the framebuffer memory, then drains
// that pipeline. Every command gives exactly one result; a finished result may wait at
// the output while the next command is taken. Both stores come out of reset unwritten,
// with no clearing pass.
`default_nettype none
module scaled_alpha_image_blit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sab_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sab_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      cmd_i,
  input  logic signed [sab_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [sab_pkg::POS_W-1:0] pos_y_i,
  input  logic [sab_pkg::BOX_W-1:0]       box_width_i,
  input  logic [sab_pkg::BOX_W-1:0]       box_height_i,
  input  logic [sab_pkg::CH_W-1:0]        red_in_i,
  input  logic [sab_pkg::CH_W-1:0]        green_in_i,
  input  logic [sab_pkg::CH_W-1:0]        blue_in_i,
  input  logic [sab_pkg::CH_W-1:0]        alpha_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sab_pkg::CH_W-1:0]        red_out_o,
  output logic [sab_pkg::CH_W-1:0]        green_out_o,
  output logic [sab_pkg::CH_W-1:0]        blue_out_o,
  output logic                            in_range_o
);

  localparam int unsigned CW   = sab_pkg::CW;
  localparam int unsigned IDW  = sab_pkg::IMG_DIM_W;
  localparam int unsigned BW   = sab_pkg::BOX_W;
  localparam int unsigned FAW  = sab_pkg::FB_AW;
  localparam int unsigned TAW  = sab_pkg::TEX_AW;
  localparam int unsigned SWW  = sab_pkg::SW_W;
  localparam int unsigned ROWW = sab_pkg::ROW_W;
  localparam int unsigned COLW = sab_pkg::COL_W;
  localparam int unsigned DVDW = sab_pkg::DVD_W;
  localparam int unsigned DVSW = sab_pkg::DVS_W;
  localparam int unsigned IRW  = sab_pkg::IMG_REG_W;
  localparam int unsigned WRW  = sab_pkg::WIN_REG_W;
  localparam int unsigned PW   = ROWW + SWW;
  localparam int unsigned PAW  = IDW + BW;
  localparam int unsigned MW   = 2 * sab_pkg::CH_W;
  localparam logic signed [CW-1:0] SCR_H_S = CW'(sab_pkg::SCREEN_MAX_H);
  localparam logic signed [CW-1:0] ONE_S   = CW'(1);
  localparam logic signed [CW-1:0] ZERO_S  = '0;

  function automatic logic [FAW-1:0] fb_addr(input logic [ROWW-1:0] row,
                                             input logic [COLW-1:0] col,
                                             input logic [SWW-1:0]  stride);
    logic [PW-1:0] prod;
    prod = row * stride;
    return FAW'(prod + PW'(col));
  endfunction

  function automatic logic [TAW-1:0] tex_addr(input logic [IDW-1:0] ty,
                                              input logic [IDW-1:0] tx);
    return TAW'(32'(ty) * sab_pkg::IMAGE_MAX_W + 32'(tx));
  endfunction

  // exact divide by 255 for sums up to 255 * 255
  function automatic logic [7:0] div255(input logic [MW-1:0] v);
    logic [MW:0] t;
    t = (MW+1)'(v) + (MW+1)'(v >> 8) + (MW+1)'(1);
    return t[15:8];
  endfunction

  // configuration registers
  logic [IRW-1:0] img_w_q, img_h_q;
  logic           img_pres_q;
  logic [WRW-1:0] win_w_q, win_h_q, off_x_q, off_y_q, scr_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q    <= IRW'(sab_pkg::IMG_W_RST);
      img_h_q    <= IRW'(sab_pkg::IMG_H_RST);
      img_pres_q <= 1'b0;
      win_w_q    <= WRW'(sab_pkg::WIN_W_RST);
      win_h_q    <= WRW'(sab_pkg::WIN_H_RST);
      off_x_q    <= '0;
      off_y_q    <= '0;
      scr_w_q    <= WRW'(sab_pkg::SCR_W_RST);
    end else if (cfg_we_i) begin
      case (sab_pkg::cfg_idx_e'(cfg_index_i))
        sab_pkg::CFG_IMG_W:    img_w_q    <= cfg_data_i[IRW-1:0];
        sab_pkg::CFG_IMG_H:    img_h_q    <= cfg_data_i[IRW-1:0];
        sab_pkg::CFG_IMG_PRES: img_pres_q <= cfg_data_i[0];
        sab_pkg::CFG_WIN_W:    win_w_q    <= cfg_data_i[WRW-1:0];
        sab_pkg::CFG_WIN_H:    win_h_q    <= cfg_data_i[WRW-1:0];
        sab_pkg::CFG_OFF_X:    off_x_q    <= cfg_data_i[WRW-1:0];
        sab_pkg::CFG_OFF_Y:    off_y_q    <= cfg_data_i[WRW-1:0];
        sab_pkg::CFG_SCR_W:    scr_w_q    <= cfg_data_i[WRW-1:0];
        default: ;
      endcase
    end
  end

  // saturated sizes and signed views
  logic [IDW-1:0]        iw, ih;
  logic [SWW-1:0]        sw;
  logic signed [CW-1:0]  iw_s, ih_s, sw_s, winw_s, winh_s, offx_s, offy_s;

  assign iw = (32'(img_w_q) > sab_pkg::IMAGE_MAX_W) ? IDW'(sab_pkg::IMAGE_MAX_W) : IDW'(img_w_q);
  assign ih = (32'(img_h_q) > sab_pkg::IMAGE_MAX_H) ? IDW'(sab_pkg::IMAGE_MAX_H) : IDW'(img_h_q);
  assign sw = (32'(scr_w_q) > sab_pkg::SCREEN_MAX_W) ? SWW'(sab_pkg::SCREEN_MAX_W)
                                                     : SWW'(scr_w_q);
  assign iw_s   = CW'(iw);
  assign ih_s   = CW'(ih);
  assign sw_s   = CW'(sw);
  assign winw_s = CW'(win_w_q);
  assign winh_s = CW'(win_h_q);
  assign offx_s = CW'(off_x_q);
  assign offy_s = CW'(off_y_q);

  sab_pkg::state_e   state_q, state_d;
  sab_pkg::div_req_t div_req;
  sab_pkg::div_rsp_t div_rsp;

  logic accept, out_load;
  logic out_valid_q;
  logic p1_valid_q, p2_valid_q;

  assign in_stall_o = (state_q != sab_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == sab_pkg::ST_FINISH) && (!out_valid_q || !out_stall_i);

  // command decode
  logic signed [CW-1:0] px_s, py_s;
  logic                 pix_ok, tex_ok;
  logic [FAW-1:0]       in_fa;
  logic [TAW-1:0]       in_ta;

  assign px_s   = CW'(pos_x_i);
  assign py_s   = CW'(pos_y_i);
  assign pix_ok = (px_s >= ZERO_S) && (px_s < sw_s) && (py_s >= ZERO_S) && (py_s < SCR_H_S);
  assign tex_ok = (px_s >= ZERO_S) && (px_s < iw_s) && (py_s >= ZERO_S) && (py_s < ih_s);
  assign in_fa  = fb_addr(py_s[ROWW-1:0], px_s[COLW-1:0], sw);
  assign in_ta  = tex_addr(py_s[IDW-1:0], px_s[IDW-1:0]);

  // draw working registers
  logic signed [CW-1:0] x_q, y_q, xmin_q, ymin_q, xmax_q, ymax_q, i_q, j_q;
  logic [BW-1:0]        w_q, h_q, rsx_q, rsy_q, rx0_q, rx_q, ry_q;
  logic [IDW-1:0]       qsx_q, qsy_q, tx0_q, tx_q, ty_q;
  logic                 flip_q;

  // aspect fit
  logic [PAW-1:0]       prod_a, prod_b;
  logic                 fit_h;
  logic [BW-1:0]        fit_q, half_u;
  logic signed [CW-1:0] half_s;

  assign prod_a = iw * h_q;
  assign prod_b = w_q * ih;
  assign fit_h  = prod_a > prod_b;
  assign fit_q  = div_rsp.quot[BW-1:0];
  assign half_u = ((flip_q ? h_q : w_q) - fit_q) >> 1;
  assign half_s = CW'(half_u);

  // clipping
  logic signed [CW-1:0] w_s, h_s, xmin_c, ymin_c, xe0, xe1, xmax_c, ye0, ye1, ymax_c;
  logic [BW:0]          dx_u, dy_u;

  always_comb begin
    w_s    = CW'(w_q);
    h_s    = CW'(h_q);
    xmin_c = (x_q < ZERO_S) ? ZERO_S : x_q;
    ymin_c = (y_q < ZERO_S) ? ZERO_S : y_q;
    xe0    = x_q + w_s;
    xe1    = (xe0 > winw_s) ? winw_s : xe0;
    xmax_c = (xe1 + offx_s > sw_s) ? sw_s - offx_s : xe1;
    ye0    = y_q + h_s;
    ye1    = (ye0 > winh_s) ? winh_s : ye0;
    ymax_c = (ye1 + offy_s > SCR_H_S) ? SCR_H_S - offy_s : ye1;
  end

  assign dx_u = (BW+1)'(xmin_q - x_q);
  assign dy_u = (BW+1)'(ymin_q - y_q);

  // nearest texel stepping
  logic [BW:0]          sum_x, sum_y;
  logic                 wrap_x, wrap_y;
  logic [BW-1:0]        rx_nx, ry_nx;
  logic [IDW-1:0]       tx_nx, ty_nx;
  logic                 col_last, row_last;
  logic signed [CW-1:0] row_sum, col_sum;
  logic [FAW-1:0]       draw_fa;
  logic [TAW-1:0]       draw_ta;

  always_comb begin
    sum_x    = (BW+1)'(rx_q) + (BW+1)'(rsx_q);
    wrap_x   = sum_x >= {1'b0, w_q};
    rx_nx    = wrap_x ? BW'(sum_x - {1'b0, w_q}) : BW'(sum_x);
    tx_nx    = tx_q + qsx_q + IDW'(wrap_x);
    sum_y    = (BW+1)'(ry_q) + (BW+1)'(rsy_q);
    wrap_y   = sum_y >= {1'b0, h_q};
    ry_nx    = wrap_y ? BW'(sum_y - {1'b0, h_q}) : BW'(sum_y);
    ty_nx    = ty_q + qsy_q + IDW'(wrap_y);
    col_last = (i_q + ONE_S) == xmax_q;
    row_last = (j_q + ONE_S) == ymax_q;
    row_sum  = j_q + offy_s;
    col_sum  = i_q + offx_s;
  end

  assign draw_fa = fb_addr(row_sum[ROWW-1:0], col_sum[COLW-1:0], sw);
  assign draw_ta = tex_addr(ty_q, tx_q);

  // stores
  logic                     tex_we, fb_we;
  logic [sab_pkg::TEX_W-1:0] tex_wdata, tex_rd;
  logic [sab_pkg::FB_W-1:0]  fb_wdata, fb_rd, blend;
  logic [FAW-1:0]            fb_waddr, fb_raddr, p1_fa_q, p2_fa_q;

  assign tex_we    = accept && (cmd_i == sab_pkg::CMD_LOAD) && tex_ok;
  assign tex_wdata = {alpha_in_i, blue_in_i, green_in_i, red_in_i};

  sab_ram #(
    .WIDTH (sab_pkg::TEX_W),
    .DEPTH (sab_pkg::IMAGE_MAX_W * sab_pkg::IMAGE_MAX_H)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .waddr_i (in_ta),
    .wdata_i (tex_wdata),
    .raddr_i (draw_ta),
    .rdata_o (tex_rd)
  );

  // blend pipeline
  logic [7:0]    alpha, inv_a;
  logic [MW-1:0] mr, mg, mb, p2_r_q, p2_g_q, p2_b_q;

  assign alpha = tex_rd[31:24];
  assign inv_a = sab_pkg::CH_MAX - alpha;
  assign mr    = alpha * tex_rd[7:0]   + inv_a * fb_rd[7:0];
  assign mg    = alpha * tex_rd[15:8]  + inv_a * fb_rd[15:8];
  assign mb    = alpha * tex_rd[23:16] + inv_a * fb_rd[23:16];
  assign blend = {div255(p2_b_q), div255(p2_g_q), div255(p2_r_q)};

  assign fb_we    = p2_valid_q || (accept && (cmd_i == sab_pkg::CMD_WRITE) && pix_ok);
  assign fb_waddr = p2_valid_q ? p2_fa_q : in_fa;
  assign fb_wdata = p2_valid_q ? blend : {blue_in_i, green_in_i, red_in_i};
  assign fb_raddr = (state_q == sab_pkg::ST_DRAW) ? draw_fa : in_fa;

  sab_ram #(
    .WIDTH (sab_pkg::FB_W),
    .DEPTH (sab_pkg::SCREEN_MAX_W * sab_pkg::SCREEN_MAX_H)
  ) u_fb_ram (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (fb_waddr),
    .wdata_i (fb_wdata),
    .raddr_i (fb_raddr),
    .rdata_o (fb_rd)
  );

  sab_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state and divider requests
  always_comb begin
    state_d = state_q;
    div_req = '0;
    case (state_q)
      sab_pkg::ST_IDLE: begin
        if (accept) begin
          case (sab_pkg::cmd_e'(cmd_i))
            sab_pkg::CMD_DRAW: state_d = sab_pkg::ST_FIT;
            sab_pkg::CMD_READ: state_d = pix_ok ? sab_pkg::ST_READ : sab_pkg::ST_FINISH;
            default:           state_d = sab_pkg::ST_FINISH;
          endcase
        end
      end
      sab_pkg::ST_READ: state_d = sab_pkg::ST_FINISH;
      sab_pkg::ST_FIT: begin
        if (!img_pres_q || iw == '0 || ih == '0 || sw == '0) begin
          state_d = sab_pkg::ST_FINISH;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = fit_h ? DVDW'(prod_b) : DVDW'(prod_a);
          div_req.divisor  = fit_h ? DVSW'(iw) : DVSW'(ih);
          state_d          = sab_pkg::ST_FITW;
        end
      end
      sab_pkg::ST_FITW: begin
        if (div_rsp.done) begin
          state_d = sab_pkg::ST_CLIP;
        end
      end
      sab_pkg::ST_CLIP: begin
        state_d = (w_q == '0 || h_q == '0) ? sab_pkg::ST_FINISH : sab_pkg::ST_CHK;
      end
      sab_pkg::ST_CHK: begin
        if (xmin_q >= xmax_q || ymin_q >= ymax_q) begin
          state_d = sab_pkg::ST_FINISH;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DVDW'(iw);
          div_req.divisor  = w_q;
          state_d          = sab_pkg::ST_DSX;
        end
      end
      sab_pkg::ST_DSX: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVDW'(ih);
          div_req.divisor  = h_q;
          state_d          = sab_pkg::ST_DSY;
        end
      end
      sab_pkg::ST_DSY: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVDW'(dx_u * iw);
          div_req.divisor  = w_q;
          state_d          = sab_pkg::ST_D0X;
        end
      end
      sab_pkg::ST_D0X: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVDW'(dy_u * ih);
          div_req.divisor  = h_q;
          state_d          = sab_pkg::ST_D0Y;
        end
      end
      sab_pkg::ST_D0Y: begin
        if (div_rsp.done) begin
          state_d = sab_pkg::ST_DRAW;
        end
      end
      sab_pkg::ST_DRAW: begin
        if (col_last && row_last) begin
          state_d = sab_pkg::ST_DRAIN;
        end
      end
      sab_pkg::ST_DRAIN: begin
        if (!p1_valid_q && !p2_valid_q) begin
          state_d = sab_pkg::ST_FINISH;
        end
      end
      sab_pkg::ST_FINISH: begin
        if (out_load) begin
          state_d = sab_pkg::ST_IDLE;
        end
      end
      default: state_d = sab_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sab_pkg::ST_IDLE;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p1_valid_q  <= (state_q == sab_pkg::ST_DRAW);
      p2_valid_q  <= p1_valid_q;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // result and datapath registers
  logic [7:0] res_r_q, res_g_q, res_b_q, red_q, green_q, blue_q;
  logic       res_ok_q, ok_q;

  always_ff @(posedge clk_i) begin
    p1_fa_q <= draw_fa;
    p2_fa_q <= p1_fa_q;
    p2_r_q  <= mr;
    p2_g_q  <= mg;
    p2_b_q  <= mb;
    if (out_load) begin
      red_q   <= res_r_q;
      green_q <= res_g_q;
      blue_q  <= res_b_q;
      ok_q    <= res_ok_q;
    end
    case (state_q)
      sab_pkg::ST_IDLE: begin
        if (accept) begin
          res_r_q <= '0;
          res_g_q <= '0;
          res_b_q <= '0;
          res_ok_q <= (cmd_i == sab_pkg::CMD_LOAD) ? tex_ok
                    : (cmd_i == sab_pkg::CMD_DRAW) ? 1'b0 : pix_ok;
          x_q <= px_s;
          y_q <= py_s;
          w_q <= box_width_i;
          h_q <= box_height_i;
        end
      end
      sab_pkg::ST_READ: begin
        res_r_q <= fb_rd[7:0];
        res_g_q <= fb_rd[15:8];
        res_b_q <= fb_rd[23:16];
      end
      sab_pkg::ST_FIT: flip_q <= fit_h;
      sab_pkg::ST_FITW: begin
        if (div_rsp.done) begin
          if (flip_q) begin
            y_q <= y_q + half_s;
            h_q <= fit_q;
          end else begin
            x_q <= x_q + half_s;
            w_q <= fit_q;
          end
        end
      end
      sab_pkg::ST_CLIP: begin
        xmin_q <= xmin_c;
        ymin_q <= ymin_c;
        xmax_q <= xmax_c;
        ymax_q <= ymax_c;
      end
      sab_pkg::ST_DSX: begin
        if (div_rsp.done) begin
          qsx_q <= IDW'(div_rsp.quot);
          rsx_q <= div_rsp.rem;
        end
      end
      sab_pkg::ST_DSY: begin
        if (div_rsp.done) begin
          qsy_q <= IDW'(div_rsp.quot);
          rsy_q <= div_rsp.rem;
        end
      end
      sab_pkg::ST_D0X: begin
        if (div_rsp.done) begin
          tx0_q <= IDW'(div_rsp.quot);
          rx0_q <= div_rsp.rem;
        end
      end
      sab_pkg::ST_D0Y: begin
        if (div_rsp.done) begin
          ty_q <= IDW'(div_rsp.quot);
          ry_q <= div_rsp.rem;
          i_q  <= xmin_q;
          j_q  <= ymin_q;
          tx_q <= tx0_q;
          rx_q <= rx0_q;
        end
      end
      sab_pkg::ST_DRAW: begin
        if (col_last) begin
          i_q  <= xmin_q;
          tx_q <= tx0_q;
          rx_q <= rx0_q;
          j_q  <= j_q + ONE_S;
          ty_q <= ty_nx;
          ry_q <= ry_nx;
        end else begin
          i_q  <= i_q + ONE_S;
          tx_q <= tx_nx;
          rx_q <= rx_nx;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign in_range_o  = ok_q;

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sab_pkg::ST_IDLE) |-> (!p1_valid_q && !p2_valid_q))
    else $error("blend pipeline busy while idle");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_draw_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sab_pkg::ST_DRAW) |->
      (i_q >= xmin_q && i_q < xmax_q && j_q >= ymin_q && j_q < ymax_q))
    else $error("draw position outside clipped box");

  a_texel_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sab_pkg::ST_DRAW) |-> (tx_q < iw && ty_q < ih && rx_q < w_q && ry_q < h_q))
    else $error("texel step outside image");

endmodule
`default_nettype wire
